[sv/idf_pkg.sv]
package idf_pkg;

    // Window and sample geometry
    localparam int SAMPLE_BITS = 10;
    localparam int WINDOW_LEN  = 8;
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int FILL_BITS   = $clog2(WINDOW_LEN + 1);
    localparam int FILL_DEPTH  = 2 ** FILL_BITS;

    // Reciprocal divide: floor(sum / d) == (sum * ceil(2^K / d)) >> K
    localparam int RECIP_SHIFT = SUM_BITS + FILL_BITS;
    localparam int RECIP_BITS  = RECIP_SHIFT + 1;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

    // Register file
    localparam int LIMIT_BITS     = 10;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [LIMIT_BITS-1:0] NEAR_LIMIT_RESET = 10'd568;
    localparam logic [LIMIT_BITS-1:0] FAR_LIMIT_RESET  = 10'd104;

    // Result fields
    localparam int DIST_BITS       = 16;
    localparam int STATUS_BITS     = 2;
    localparam int IN_TDATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS  = 2 * SAMPLE_BITS + DIST_BITS;
    localparam int OUT_TDATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_BITS  = ((STATUS_BITS + 7) / 8) * 8;
    localparam int DIST_LSB        = 2 * SAMPLE_BITS;

    // Curve ROM: floor(377000 * x^-1.189), computed in Q44 fixed point
    localparam int            CURVE_DEPTH = 2 ** SAMPLE_BITS;
    localparam int            FRAC        = 44;
    localparam logic [63:0]   CURVE_NUM   = 64'd377000;
    localparam logic [63:0]   EXP_NUM     = 64'd1189;
    localparam logic [63:0]   EXP_DEN     = 64'd1000;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_NEAR_LIMIT = 1'b0,
        REG_FAR_LIMIT  = 1'b1
    } cfg_reg_t;

    typedef enum logic [STATUS_BITS-1:0] {
        RANGE_OK   = 2'd0,
        RANGE_NEAR = 2'd1,
        RANGE_FAR  = 2'd2
    } range_status_t;

    typedef struct packed {
        logic [SUM_BITS-1:0]    sum;
        logic [FILL_BITS-1:0]   fill;
        logic [SAMPLE_BITS-1:0] raw;
    } win_t;

    typedef struct packed {
        logic load_b;
        logic load_c;
    } stage_ctl_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] raw;
        logic [SAMPLE_BITS-1:0] filt;
        range_status_t          status;
        logic [DIST_BITS-1:0]   rom;
    } res_t;

    typedef logic [DIST_BITS-1:0]  curve_rom_t [CURVE_DEPTH];
    typedef logic [RECIP_BITS-1:0] recip_rom_t [FILL_DEPTH];

    // Shift-subtract divide, used only while building constant tables
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[FRAC+63:FRAC];
    endfunction

    // 2 * atanh(num / den)
    function automatic logic [63:0] atanh_twice(input logic [63:0] num,
                                                input logic [63:0] den);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] acc;
        z    = udiv64(num << FRAC, den);
        z2   = mulq(z, z);
        term = z;
        acc  = '0;
        for (int i = 1; i < 100; i += 2) begin
            if (term != 64'd0) begin
                acc  = acc + udiv64(term, 64'(i));
                term = mulq(term, z2);
            end
        end
        return acc << 1;
    endfunction

    function automatic logic [63:0] ln_q(input logic [63:0] x, input logic [63:0] ln2);
        logic [63:0] k;
        logic [63:0] p;
        k = '0;
        for (int j = 0; j < 40; j++) begin
            if (k == 64'(j) && (x >> (k + 64'd1)) != 64'd0)
                k = k + 64'd1;
        end
        p = 64'd1 << k;
        return k * ln2 + atanh_twice(x - p, x + p);
    endfunction

    function automatic logic [DIST_BITS-1:0] curve_value(input logic [63:0] x,
                                                         input logic [63:0] lc,
                                                         input logic [63:0] ln2);
        logic [63:0] lx;
        logic [63:0] lv;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] v;
        logic        done;
        if (x == 64'd0)
            return DIST_MAX;
        lx = udiv64(ln_q(x, ln2) * EXP_NUM, EXP_DEN);
        if (lx > lc)
            return '0;
        lv = lc - lx;
        n  = udiv64(lv, ln2);
        if (n >= 64'd16)
            return DIST_MAX;
        r    = lv - n * ln2;
        acc  = 64'd1 << FRAC;
        term = 64'd1 << FRAC;
        done = 1'b0;
        for (int i = 1; i < 60; i++) begin
            if (!done) begin
                term = udiv64(mulq(term, r), 64'(i));
                if (term == 64'd0)
                    done = 1'b1;
                else
                    acc = acc + term;
            end
        end
        v = (acc << n) >> FRAC;
        return (v > 64'(DIST_MAX)) ? DIST_MAX : v[DIST_BITS-1:0];
    endfunction

    function automatic curve_rom_t build_curve();
        curve_rom_t  t;
        logic [63:0] ln2;
        logic [63:0] lc;
        ln2 = atanh_twice(64'd1, 64'd3);
        lc  = ln_q(CURVE_NUM, ln2);
        for (int x = 0; x < CURVE_DEPTH; x++)
            t[x] = curve_value(64'(x), lc, ln2);
        return t;
    endfunction

    // ceil(2^RECIP_SHIFT / d); the zero entry is never read
    function automatic recip_rom_t build_recip();
        recip_rom_t t;
        for (int d = 0; d < FILL_DEPTH; d++) begin
            if (d == 0)
                t[d] = '0;
            else
                t[d] = RECIP_BITS'(udiv64((64'd1 << RECIP_SHIFT) + 64'(d) - 64'd1,
                                          64'(d)));
        end
        return t;
    endfunction

    localparam curve_rom_t CURVE_ROM = build_curve();
    localparam recip_rom_t RECIP_ROM = build_recip();

endpackage

[sv/idf_cell.sv]
// One window slot: load the neighbor's sample on shift.
module idf_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             shift_en,
    input  logic [idf_pkg::SAMPLE_BITS-1:0]  d_in,
    output logic [idf_pkg::SAMPLE_BITS-1:0]  q
);

    logic [idf_pkg::SAMPLE_BITS-1:0] q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg <= '0;
        else if (shift_en)
            q_reg <= d_in;
    end

    assign q = q_reg;

endmodule

[sv/idf_window.sv]
// Row of sample cells with running sum and fill count.
module idf_window (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic [idf_pkg::SAMPLE_BITS-1:0]  sample,
    output idf_pkg::win_t                    win
);

    logic [idf_pkg::SAMPLE_BITS-1:0] tap [idf_pkg::WINDOW_LEN];
    logic [idf_pkg::SUM_BITS-1:0]    sum_reg, sum_next;
    logic [idf_pkg::FILL_BITS-1:0]   fill_reg, fill_next;
    logic [idf_pkg::SAMPLE_BITS-1:0] raw_reg;

    genvar gi;
    generate
        for (gi = 0; gi < idf_pkg::WINDOW_LEN; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                idf_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (push),
                    .d_in     (sample),
                    .q        (tap[gi])
                );
            end
            else
            begin : g_body
                idf_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (push),
                    .d_in     (tap[gi-1]),
                    .q        (tap[gi])
                );
            end
        end
    endgenerate

    // Drop the oldest sample, add the new one
    always_comb
    begin
        sum_next = sum_reg - idf_pkg::SUM_BITS'(tap[idf_pkg::WINDOW_LEN-1])
                           + idf_pkg::SUM_BITS'(sample);
        if (fill_reg < idf_pkg::FILL_BITS'(idf_pkg::WINDOW_LEN))
            fill_next = fill_reg + idf_pkg::FILL_BITS'(1);
        else
            fill_next = fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            fill_reg <= '0;
        end
        else if (push)
        begin
            sum_reg  <= sum_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            raw_reg <= sample;
    end

    assign win.sum  = sum_reg;
    assign win.fill = fill_reg;
    assign win.raw  = raw_reg;

endmodule

[sv/idf_classify.sv]
// Mean by reciprocal multiply, then limit compare and curve lookup.
module idf_classify (
    input  logic                             clk,
    input  idf_pkg::stage_ctl_t              ctl,
    input  idf_pkg::win_t                    win,
    input  logic [idf_pkg::LIMIT_BITS-1:0]   near_limit,
    input  logic [idf_pkg::LIMIT_BITS-1:0]   far_limit,
    output idf_pkg::res_t                    res
);

    logic [idf_pkg::PROD_BITS-1:0]   prod;
    logic [idf_pkg::SAMPLE_BITS-1:0] filt_b_reg;
    logic [idf_pkg::SAMPLE_BITS-1:0] raw_b_reg;
    logic [idf_pkg::SAMPLE_BITS-1:0] filt_c_reg;
    logic [idf_pkg::SAMPLE_BITS-1:0] raw_c_reg;
    logic [idf_pkg::DIST_BITS-1:0]   rom_c_reg;
    idf_pkg::range_status_t          status_c_reg, status_next;

    assign prod = idf_pkg::PROD_BITS'(win.sum)
                * idf_pkg::PROD_BITS'(idf_pkg::RECIP_ROM[win.fill]);

    always_comb
    begin
        if (idf_pkg::LIMIT_BITS'(filt_b_reg) > near_limit)
            status_next = idf_pkg::RANGE_NEAR;
        else if (idf_pkg::LIMIT_BITS'(filt_b_reg) < far_limit)
            status_next = idf_pkg::RANGE_FAR;
        else
            status_next = idf_pkg::RANGE_OK;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_b)
        begin
            filt_b_reg <= prod[idf_pkg::RECIP_SHIFT +: idf_pkg::SAMPLE_BITS];
            raw_b_reg  <= win.raw;
        end
        if (ctl.load_c)
        begin
            filt_c_reg   <= filt_b_reg;
            raw_c_reg    <= raw_b_reg;
            status_c_reg <= status_next;
            rom_c_reg    <= idf_pkg::CURVE_ROM[filt_b_reg];
        end
    end

    assign res.raw    = raw_c_reg;
    assign res.filt   = filt_c_reg;
    assign res.status = status_c_reg;
    assign res.rom    = rom_c_reg;

endmodule

[sv/ir_distance_filter_classify_core.sv]
// Channel   | Signals                              | Payload (lowest bit first)
// ----------+--------------------------------------+------------------------------------------
// sample in | s_axis_tvalid/tready/tdata           | tdata: sample[9:0], zero pad
// result out| m_axis_tvalid/tready/tdata/tuser     | tdata: raw_echo, filtered_value,
//           |                                      |        distance_mm, zero pad
//           |                                      | tuser: range_status, zero pad
// config    | cfg_we/cfg_index/cfg_data            | 0 near_limit, 1 far_limit
//
// After a sample is accepted, its result is built in steps: the window cells shift and
// the running sum updates at accept, the mean is formed by one reciprocal multiply, then
// limits are compared and the curve ROM is read, then the result register loads. A new
// sample is taken only once the last has left the compute stages, one item at a time.
// Reset clears the window cells, sum, fill count and all valid flags, and loads the
// limit registers with their defaults. A stalled result holds in the output register
// while the next item computes; that item waits in the last stage until it frees.
module ir_distance_filter_classify_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [idf_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,   // sample
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [idf_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,   // raw_echo, filtered_value,
                                                                 // distance_mm
    output logic [idf_pkg::OUT_TUSER_BITS-1:0]   m_axis_tuser,   // range_status
    input  logic                                 cfg_we,
    input  logic [idf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [idf_pkg::LIMIT_BITS-1:0]       cfg_data
);

    logic [idf_pkg::LIMIT_BITS-1:0]     near_reg;
    logic [idf_pkg::LIMIT_BITS-1:0]     far_reg;
    logic                               v_a_reg, v_b_reg, v_c_reg;
    logic                               v_c_next;
    logic                               out_valid_reg, out_valid_next;
    logic [idf_pkg::OUT_TDATA_BITS-1:0] out_data_reg;
    logic [idf_pkg::OUT_TUSER_BITS-1:0] out_user_reg;
    logic [idf_pkg::DIST_BITS-1:0]      dist_mm;
    logic                               push;
    logic                               out_take;
    logic                               c_to_out;
    idf_pkg::win_t                      win;
    idf_pkg::stage_ctl_t                ctl;
    idf_pkg::res_t                      res;

    // Limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg <= idf_pkg::NEAR_LIMIT_RESET;
            far_reg  <= idf_pkg::FAR_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (idf_pkg::cfg_reg_t'(cfg_index))
                idf_pkg::REG_NEAR_LIMIT: near_reg <= cfg_data;
                idf_pkg::REG_FAR_LIMIT:  far_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // One item in the compute stages at a time
    assign s_axis_tready = !(v_a_reg || v_b_reg || v_c_reg);
    assign push          = s_axis_tvalid && s_axis_tready;

    // Advance the last stage when the output register is free or being drained
    assign out_take = !out_valid_reg || m_axis_tready;
    assign c_to_out = v_c_reg && out_take;

    assign ctl.load_b = v_a_reg;
    assign ctl.load_c = v_b_reg;

    always_comb
    begin
        v_c_next       = v_b_reg || (v_c_reg && !out_take);
        out_valid_next = c_to_out || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg       <= 1'b0;
            v_b_reg       <= 1'b0;
            v_c_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v_a_reg       <= push;
            v_b_reg       <= v_a_reg;
            v_c_reg       <= v_c_next;
            out_valid_reg <= out_valid_next;
        end
    end

    idf_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .sample (s_axis_tdata[idf_pkg::SAMPLE_BITS-1:0]),
        .win    (win)
    );

    idf_classify u_classify (
        .clk        (clk),
        .ctl        (ctl),
        .win        (win),
        .near_limit (near_reg),
        .far_limit  (far_reg),
        .res        (res)
    );

    // Zero the distance whenever the mean is outside the limits
    assign dist_mm = (res.status == idf_pkg::RANGE_OK) ? res.rom : '0;

    always_ff @(posedge clk)
    begin
        if (c_to_out)
        begin
            out_data_reg <= idf_pkg::OUT_TDATA_BITS'({dist_mm, res.filt, res.raw});
            out_user_reg <= idf_pkg::OUT_TUSER_BITS'(res.status);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({v_a_reg, v_b_reg, v_c_reg}))
        else $error("more than one compute stage busy");

    a_push_starts: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (v_a_reg && !s_axis_tready))
        else $error("accepted sample did not enter the first stage");

    a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[idf_pkg::STATUS_BITS-1:0] != idf_pkg::RANGE_OK)
        |-> (m_axis_tdata[idf_pkg::DIST_LSB +: idf_pkg::DIST_BITS] == '0))
        else $error("distance not zero for out-of-range result");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v_c_reg && out_valid_reg && !m_axis_tready) |=> (v_c_reg && out_valid_reg))
        else $error("stalled result lost");

endmodule

[tb/sv/idf_reading_check.sv]
`timescale 1ns / 1ps

module idf_reading_check
    import idf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    input  logic [OUT_TUSER_BITS-1:0] m_axis_tuser,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [LIMIT_BITS-1:0]     cfg_data,
    output int                        mismatches,
    output int                        pending
);

    logic [DIST_BITS-1:0]   mm_curve [CURVE_DEPTH];
    logic [SAMPLE_BITS-1:0] ring [WINDOW_LEN];
    logic [2:0]             ring_slot;
    logic [SUM_BITS-1:0]    ring_sum;
    logic [3:0]             ring_fill;
    logic [LIMIT_BITS-1:0]  near_lim;
    logic [LIMIT_BITS-1:0]  far_lim;
    res_t                   expected_readings [$];

    // (a * b) >> FRAC over the full 128-bit product
    function automatic longint unsigned q44_mul(input longint unsigned a,
                                                input longint unsigned b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[FRAC+63:FRAC];
    endfunction

    // 2 * atanh(num / den) by its odd power series
    function automatic longint unsigned twice_atanh(input longint unsigned num,
                                                    input longint unsigned den);
        longint unsigned z;
        longint unsigned z_sq;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned k;
        z    = (num << FRAC) / den;
        z_sq = q44_mul(z, z);
        term = z;
        acc  = 0;
        k    = 1;
        while (k < 100 && term != 0) begin
            acc  = acc + term / k;
            term = q44_mul(term, z_sq);
            k    = k + 2;
        end
        return acc << 1;
    endfunction

    function automatic longint unsigned log_q44(input longint unsigned x,
                                                input longint unsigned ln2);
        longint unsigned k;
        longint unsigned pow2;
        k = 0;
        while (k < 40 && (x >> (k + 1)) != 0)
            k = k + 1;
        pow2 = 64'd1 << k;
        return k * ln2 + twice_atanh(x - pow2, x + pow2);
    endfunction

    // 377000 * x^-1.189 through exp(ln 377000 - 1.189 ln x), saturated
    function automatic logic [DIST_BITS-1:0] curve_at(input longint unsigned x,
                                                      input longint unsigned ln_num,
                                                      input longint unsigned ln2);
        longint unsigned lx;
        longint unsigned lv;
        longint unsigned n;
        longint unsigned r;
        longint unsigned acc;
        longint unsigned term;
        longint unsigned k;
        longint unsigned v;
        if (x == 0)
            return DIST_MAX;
        lx = log_q44(x, ln2) * EXP_NUM / EXP_DEN;
        if (lx > ln_num)
            return '0;
        lv = ln_num - lx;
        n  = lv / ln2;
        if (n >= 16)
            return DIST_MAX;
        r    = lv - n * ln2;
        acc  = 64'd1 << FRAC;
        term = 64'd1 << FRAC;
        k    = 1;
        // a zero term adds nothing, so stop on it
        while (k < 60 && term != 0) begin
            term = q44_mul(term, r) / k;
            acc  = acc + term;
            k    = k + 1;
        end
        v = (acc << n) >> FRAC;
        return (v > 64'(DIST_MAX)) ? DIST_MAX : v[DIST_BITS-1:0];
    endfunction

    initial begin
        longint unsigned ln2;
        longint unsigned ln_num;
        ln2    = twice_atanh(1, 3);
        ln_num = log_q44(CURVE_NUM, ln2);
        for (int x = 0; x < CURVE_DEPTH; x++)
            mm_curve[x] = curve_at(x, ln_num, ln2);
    end

    // Push one sample into the window and classify the new mean
    function automatic res_t advance_window(input logic [SAMPLE_BITS-1:0] smp);
        res_t                   r;
        logic [SAMPLE_BITS-1:0] mean;
        ring_sum        = ring_sum - SUM_BITS'(ring[ring_slot]) + SUM_BITS'(smp);
        ring[ring_slot] = smp;
        ring_slot       = ring_slot + 3'd1;
        if (ring_fill < WINDOW_LEN)
            ring_fill = ring_fill + 4'd1;
        mean     = SAMPLE_BITS'(ring_sum / ring_fill);
        r.raw    = smp;
        r.filt   = mean;
        r.rom    = '0;
        if (mean > near_lim)
            r.status = RANGE_NEAR;
        else if (mean < far_lim)
            r.status = RANGE_FAR;
        else begin
            r.status = RANGE_OK;
            r.rom    = mm_curve[mean];
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        res_t want;
        if (!rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++)
                ring[i] = '0;
            ring_slot  = '0;
            ring_sum   = '0;
            ring_fill  = '0;
            near_lim   = NEAR_LIMIT_RESET;
            far_lim    = FAR_LIMIT_RESET;
            expected_readings.delete();
            mismatches = 0;
            pending    = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_NEAR_LIMIT: near_lim = cfg_data;
                    REG_FAR_LIMIT:  far_lim  = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_readings.push_back(advance_window(s_axis_tdata[SAMPLE_BITS-1:0]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t: result with none expected, actual tdata %h tuser %h",
                             $time, m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end
                else begin
                    want = expected_readings.pop_front();
                    check_field("raw_echo", want.raw, m_axis_tdata[SAMPLE_BITS-1:0]);
                    check_field("filtered_value", want.filt,
                                m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
                    check_field("range_status", want.status, m_axis_tuser[STATUS_BITS-1:0]);
                    check_field("distance_mm", want.rom,
                                m_axis_tdata[DIST_LSB+DIST_BITS-1:DIST_LSB]);
                end
            end
            pending = expected_readings.size();
        end
    end

endmodule

[tb/sv/ir_distance_filter_classify_core_tb.sv]
`timescale 1ns / 1ps

module ir_distance_filter_classify_core_tb;
    import idf_pkg::*;

    localparam int RESET_CYCLES  = 8;
    localparam int STALL_LIMIT   = 1000;   // cycles with no handshake before giving up
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 113;
    localparam int LONG_HOLD     = 60;     // receiver hold, long enough to back up the input
    localparam int LONG_HOLD_AT  = 400;    // item count at which the long hold starts
    localparam int CALM_FROM     = 1038;   // no idling on either side from here on
    localparam int SAMPLE_TOP    = 2 ** SAMPLE_BITS - 1;

    logic                      clk;
    logic                      rst_n         = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;   // sample, zero pad
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;         // raw_echo, filtered_value, distance_mm
    logic [OUT_TUSER_BITS-1:0] m_axis_tuser;         // range_status
    logic                      cfg_we        = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index     = '0;
    logic [LIMIT_BITS-1:0]     cfg_data      = '0;

    int items_sent = 0;
    int range_errors;
    int readings_pending;
    int quiet_cycles = 0;

    ir_distance_filter_classify_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Predict every accepted sample and compare each result against it
    idf_reading_check range_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (range_errors),
        .pending       (readings_pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: any accepted item or register write resets the count
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, readings_pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold to fill the block, calm at the end.
    // In one hundred-item stretch out of every four, no new stall bursts start.
    initial begin
        int  stall_left;
        int  hold_left;
        bit  hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever begin
            @(negedge clk);
            if (!hold_done && items_sent >= LONG_HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else begin
                m_axis_tready <= 1'b1;
                if (items_sent < CALM_FROM && (items_sent / 100) % 4 != 2
                        && $urandom_range(0, 6) == 0)
                    stall_left = $urandom_range(1, 8);
            end
        end
    end

    // Write one limit register; only called with nothing in flight
    task automatic write_limit(input cfg_reg_t idx, input logic [LIMIT_BITS-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Offer one sample and hold it until the block takes it
    task automatic send_sample(input int value);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_BITS'(value);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic wait_all_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (readings_pending != 0)
            @(negedge clk);
    endtask

    initial begin
        int near_v;
        int far_v;
        int level;
        int smp;
        int gap_odds;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Fill-up from reset with the default limits: extremes, alternating bits,
        // window wrap after the eighth sample.
        send_sample(SAMPLE_TOP);
        send_sample(0);
        send_sample(512);
        send_sample(700);
        send_sample(100);
        send_sample(341);
        send_sample(682);
        send_sample(300);
        send_sample(300);

        // Widest limits: everything in range; flush the window to zero so the
        // zero entry of the curve (infinite distance) is read.
        wait_all_results();
        write_limit(REG_NEAR_LIMIT, LIMIT_BITS'(SAMPLE_TOP));
        write_limit(REG_FAR_LIMIT, '0);
        send_sample(SAMPLE_TOP);
        repeat (8) send_sample(0);

        // Crossed limits: the too-close test must win over too-far
        wait_all_results();
        write_limit(REG_NEAR_LIMIT, '0);
        write_limit(REG_FAR_LIMIT, LIMIT_BITS'(SAMPLE_TOP));
        send_sample(0);
        send_sample(5);
        send_sample(40);

        for (int p = 0; p < PHASES; p++) begin
            wait_all_results();
            case (p % 5)
                0: begin
                    near_v = $urandom_range(300, SAMPLE_TOP);
                    far_v  = $urandom_range(0, near_v);
                end
                1: begin
                    near_v = SAMPLE_TOP;
                    far_v  = 0;
                end
                2: begin
                    near_v = 0;
                    far_v  = SAMPLE_TOP;
                end
                3: begin
                    far_v  = $urandom_range(200, SAMPLE_TOP);
                    near_v = $urandom_range(0, far_v);
                end
                default: begin
                    near_v = $urandom_range(0, SAMPLE_TOP);
                    far_v  = $urandom_range(0, SAMPLE_TOP);
                end
            endcase
            if (p == PHASES - 1) begin
                near_v = NEAR_LIMIT_RESET;
                far_v  = FAR_LIMIT_RESET;
            end
            write_limit(REG_NEAR_LIMIT, LIMIT_BITS'(near_v));
            write_limit(REG_FAR_LIMIT, LIMIT_BITS'(far_v));

            // no sender gaps in one middle phase and in the last one
            gap_odds = (p == 5 || p == PHASES - 1) ? 0 : ((p % 2) ? 4 : 10);
            level    = $urandom_range(0, SAMPLE_TOP);

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // move the level the window settles on; favor the limits so the
                // mean crosses them and lands right on them
                if (i % 12 == 0) begin
                    case ($urandom_range(0, 3))
                        0: level = near_v;
                        1: level = far_v;
                        2: level = $urandom_range(0, SAMPLE_TOP);
                        default: level = (near_v + far_v) / 2;
                    endcase
                end
                case ($urandom_range(0, 9))
                    0: smp = 0;
                    1: smp = SAMPLE_TOP;
                    2, 3: smp = $urandom_range(0, SAMPLE_TOP);
                    default: begin
                        smp = level + int'($urandom_range(0, 16)) - 8;
                        if (smp < 0)
                            smp = 0;
                        if (smp > SAMPLE_TOP)
                            smp = SAMPLE_TOP;
                    end
                endcase
                send_sample(smp);

                if (p == 3 && i == 50)
                    wait_all_results();
                else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
                    pause_sender($urandom_range(1, 8));
            end
        end

        wait_all_results();
        repeat (8) @(posedge clk);
        if (range_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
